FILE: hdl/shzw_pkg.sv
// Package for the stable heading zero-and-wrap block: widths, codes and constants.
`timescale 1ns / 1ps

package shzw_pkg;

  // Field widths
  localparam int unsigned YawW    = 16;
  localparam int unsigned ValueW  = 17;
  localparam int unsigned KindW   = 2;
  localparam int unsigned LenW    = 11;
  localparam int unsigned PosW    = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned OutDataW = 24;

  // Angle limits in hundredths of a degree
  localparam logic signed [YawW-1:0]   YawLimit    = 16'sd18000;
  localparam logic signed [ValueW-1:0] YawLimitV   = 17'sd18000;
  localparam logic signed [ValueW-1:0] FullTurnV   = 17'sd36000;

  // Window length limits and register reset values
  localparam logic [LenW-1:0] MaxWindow       = 11'd1024;
  localparam logic [LenW-1:0] ResetWindow     = 11'd20;
  localparam logic [CfgW-1:0] ResetThreshold  = 16'd5;
  localparam logic [CfgW-1:0] ResetTolerance  = 16'd100;

  // Report kinds
  typedef enum logic [KindW-1:0] {
    KIND_UNSTABLE = 2'd0,
    KIND_CAL_DONE = 2'd1,
    KIND_HEADING  = 2'd2
  } report_kind_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LENGTH    = 2'd0,
    CFG_STABLE_THRESHOLD = 2'd1,
    CFG_SETTLE_TOLERANCE = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_t;

endpackage

FILE: hdl/stable_heading_zero_and_wrap.sv
// Top level of the stable heading zero-and-wrap block.
//
// Channel | Direction | Handshake          | Payload
// s_*     | in        | s_tvalid/s_tready  | s_tdata[15:0] yaw_sample
// m_*     | out       | m_tvalid/m_tready  | m_tdata[16:0] report_value, m_tuser[1:0] report_kind
// cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: an item is held in the input
// register, then its result (if any) lands in the output register.
// Synchronous reset restores the register defaults and restarts calibration.
// A stalled output register holds the input register, which, once full, holds s_tready low.
`timescale 1ns / 1ps

module stable_heading_zero_and_wrap (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [15:0] yaw_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [16:0] report_value, [23:17] zero
  output logic [1:0]  m_tuser,    // [1:0] report_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [shzw_pkg::LenW-1:0] window_len;
  logic [shzw_pkg::CfgW-1:0] stable_threshold;
  logic [shzw_pkg::CfgW-1:0] settle_tolerance;

  // Input register
  logic                              in_valid;
  logic signed [shzw_pkg::YawW-1:0]  in_yaw;
  logic signed [shzw_pkg::YawW-1:0]  yaw_clamped;

  // Block state
  logic                              calibrated, calibrated_next;
  logic [shzw_pkg::PosW-1:0]         window_position, window_position_next;
  logic signed [shzw_pkg::YawW-1:0]  window_min, window_min_next;
  logic signed [shzw_pkg::YawW-1:0]  window_max, window_max_next;
  logic signed [shzw_pkg::YawW-1:0]  initial_heading, initial_heading_next;
  logic signed [shzw_pkg::YawW-1:0]  candidate_heading, candidate_heading_next;
  logic                              have_candidate, have_candidate_next;

  // Result
  logic                              res_valid;
  shzw_pkg::report_kind_t            res_kind;
  logic signed [shzw_pkg::ValueW-1:0] res_value;
  logic                              out_valid;
  shzw_pkg::report_kind_t            out_kind;
  logic signed [shzw_pkg::ValueW-1:0] out_value;

  // Datapath intermediates
  logic signed [shzw_pkg::ValueW-1:0] range_v, sum_v, mid_v, gap_v, mag_v, diff_v;
  logic [shzw_pkg::LenW-1:0]          pos_plus;
  logic                               advance;

  // Move the input register on when the output register is free or being taken
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Saturate the sample into the yaw range
  always_comb begin
    if ($signed(s_tdata) > shzw_pkg::YawLimit) begin
      yaw_clamped = shzw_pkg::YawLimit;
    end else if ($signed(s_tdata) < -shzw_pkg::YawLimit) begin
      yaw_clamped = -shzw_pkg::YawLimit;
    end else begin
      yaw_clamped = $signed(s_tdata);
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_yaw <= yaw_clamped;
    end
  end

  // Configuration writes; store the window length already limited to 1..1024
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len       <= shzw_pkg::ResetWindow;
      stable_threshold <= shzw_pkg::ResetThreshold;
      settle_tolerance <= shzw_pkg::ResetTolerance;
    end else if (cfg_valid) begin
      unique case (shzw_pkg::cfg_index_t'(cfg_index))
        shzw_pkg::CFG_WINDOW_LENGTH: begin
          if (cfg_data[shzw_pkg::LenW-1:0] == '0) begin
            window_len <= shzw_pkg::LenW'(1);
          end else if (cfg_data[shzw_pkg::LenW-1:0] > shzw_pkg::MaxWindow) begin
            window_len <= shzw_pkg::MaxWindow;
          end else begin
            window_len <= cfg_data[shzw_pkg::LenW-1:0];
          end
        end
        shzw_pkg::CFG_STABLE_THRESHOLD: stable_threshold <= cfg_data;
        shzw_pkg::CFG_SETTLE_TOLERANCE: settle_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-item work: calibration windows, then candidate/check pairs
  always_comb begin
    calibrated_next        = calibrated;
    window_position_next   = window_position;
    window_min_next        = window_min;
    window_max_next        = window_max;
    initial_heading_next   = initial_heading;
    candidate_heading_next = candidate_heading;
    have_candidate_next    = have_candidate;
    res_valid              = 1'b0;
    res_kind               = shzw_pkg::KIND_UNSTABLE;
    res_value              = '0;
    range_v                = '0;
    sum_v                  = '0;
    mid_v                  = '0;
    gap_v                  = '0;
    mag_v                  = '0;
    diff_v                 = '0;
    pos_plus               = {1'b0, window_position} + shzw_pkg::LenW'(1);

    if (!calibrated) begin
      // Track min and max; nonzero samples only after the first
      if (window_position == '0) begin
        window_min_next = in_yaw;
        window_max_next = in_yaw;
      end else if (in_yaw != '0) begin
        if (in_yaw < window_min) window_min_next = in_yaw;
        if (in_yaw > window_max) window_max_next = in_yaw;
      end
      range_v = {window_max_next[shzw_pkg::YawW-1], window_max_next}
              - {window_min_next[shzw_pkg::YawW-1], window_min_next};
      sum_v   = {window_max_next[shzw_pkg::YawW-1], window_max_next}
              + {window_min_next[shzw_pkg::YawW-1], window_min_next};
      mid_v   = sum_v >>> 1;
      if (pos_plus >= window_len) begin
        window_position_next = '0;
        res_valid            = 1'b1;
        if ($unsigned(range_v) < {1'b0, stable_threshold}) begin
          initial_heading_next = mid_v[shzw_pkg::YawW-1:0];
          calibrated_next      = 1'b1;
          have_candidate_next  = 1'b0;
          res_kind             = shzw_pkg::KIND_CAL_DONE;
          res_value            = mid_v;
        end else begin
          res_kind  = shzw_pkg::KIND_UNSTABLE;
          res_value = range_v;
        end
      end else begin
        window_position_next = pos_plus[shzw_pkg::PosW-1:0];
      end
    end else if (!have_candidate) begin
      candidate_heading_next = in_yaw;
      have_candidate_next    = 1'b1;
    end else begin
      // Check the candidate, then wrap its offset from the initial heading
      have_candidate_next = 1'b0;
      gap_v  = {in_yaw[shzw_pkg::YawW-1], in_yaw}
             - {candidate_heading[shzw_pkg::YawW-1], candidate_heading};
      mag_v  = (gap_v < 0) ? -gap_v : gap_v;
      diff_v = {candidate_heading[shzw_pkg::YawW-1], candidate_heading}
             - {initial_heading[shzw_pkg::YawW-1], initial_heading};
      if ($unsigned(mag_v) <= {1'b0, settle_tolerance}) begin
        res_valid = 1'b1;
        res_kind  = shzw_pkg::KIND_HEADING;
        if (diff_v > shzw_pkg::YawLimitV) begin
          res_value = diff_v - shzw_pkg::FullTurnV;
        end else if (diff_v < -shzw_pkg::YawLimitV) begin
          res_value = diff_v + shzw_pkg::FullTurnV;
        end else begin
          res_value = diff_v;
        end
      end
    end
  end

  // Update state as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated        <= 1'b0;
      window_position   <= '0;
      window_min        <= '0;
      window_max        <= '0;
      initial_heading   <= '0;
      candidate_heading <= '0;
      have_candidate    <= 1'b0;
    end else if (advance) begin
      calibrated        <= calibrated_next;
      window_position   <= window_position_next;
      window_min        <= window_min_next;
      window_max        <= window_max_next;
      initial_heading   <= initial_heading_next;
      candidate_heading <= candidate_heading_next;
      have_candidate    <= have_candidate_next;
    end
  end

  // Output register: load a new result, or drop one that was taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && res_valid) begin
      out_kind  <= res_kind;
      out_value <= res_value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(shzw_pkg::OutDataW - shzw_pkg::ValueW){1'b0}}, out_value};
  assign m_tuser  = out_kind;

endmodule

FILE: test/tb_stable_heading_zero_and_wrap.sv
// Self-checking testbench for the stable heading zero-and-wrap block.
`timescale 1ns / 1ps

module tb_stable_heading_zero_and_wrap;

  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    shzw_pkg::report_kind_t             kind;
    logic signed [shzw_pkg::ValueW-1:0] value;
  } report_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // [15:0] yaw_sample
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;          // [16:0] report_value, [23:17] zero
  logic [1:0]  m_tuser;          // [1:0] report_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // Stimulus and expected reports
  logic [shzw_pkg::YawW-1:0] sample_queue[$];
  report_t                   pending_reports[$];
  int              samples_queued = 0;
  int              samples_taken  = 0;
  int              error_count    = 0;
  int              quiet_cycles   = 0;
  int              send_wait      = 0;
  int              stall_left     = 0;
  bit              send_idle      = 1'b0;
  bit              recv_idle      = 1'b0;
  bit              long_hold      = 1'b0;
  bit              long_hold_done = 1'b0;

  // Register copies
  logic [shzw_pkg::LenW-1:0] reg_win_len   = shzw_pkg::ResetWindow;
  logic [shzw_pkg::CfgW-1:0] reg_threshold = shzw_pkg::ResetThreshold;
  logic [shzw_pkg::CfgW-1:0] reg_tolerance = shzw_pkg::ResetTolerance;

  // Heading state copies
  bit                               cal_locked   = 1'b0;
  logic [shzw_pkg::PosW-1:0]        win_pos      = '0;
  logic signed [shzw_pkg::YawW-1:0] win_lo       = '0;
  logic signed [shzw_pkg::YawW-1:0] win_hi       = '0;
  logic signed [shzw_pkg::YawW-1:0] zero_heading = '0;
  logic signed [shzw_pkg::YawW-1:0] cand_heading = '0;
  bit                               cand_held    = 1'b0;

  stable_heading_zero_and_wrap DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the heading state by one sample and return the report it causes
  function automatic void predict_report(input logic [shzw_pkg::YawW-1:0] raw,
                                         output bit has, output report_t rep);
    logic signed [shzw_pkg::YawW-1:0]   yaw;
    logic [shzw_pkg::LenW-1:0]          len;
    logic signed [shzw_pkg::ValueW-1:0] span;
    logic signed [shzw_pkg::ValueW-1:0] total;
    logic signed [shzw_pkg::ValueW-1:0] gap;
    logic signed [shzw_pkg::ValueW-1:0] rel;
    yaw = $signed(raw);
    has = 1'b0;
    rep = '0;
    if (yaw > shzw_pkg::YawLimit) yaw = shzw_pkg::YawLimit;
    else if (yaw < -shzw_pkg::YawLimit) yaw = -shzw_pkg::YawLimit;

    if (!cal_locked) begin
      len = reg_win_len;
      if (len == '0) len = shzw_pkg::LenW'(1);
      if (len > shzw_pkg::MaxWindow) len = shzw_pkg::MaxWindow;
      // First sample of a window seeds both bounds; later zeros are skipped
      if (win_pos == '0) begin
        win_lo = yaw;
        win_hi = yaw;
      end else if (yaw != '0) begin
        if (yaw < win_lo) win_lo = yaw;
        if (yaw > win_hi) win_hi = yaw;
      end
      if ({1'b0, win_pos} + 11'd1 >= len) begin
        win_pos = '0;
        span = shzw_pkg::ValueW'(win_hi) - shzw_pkg::ValueW'(win_lo);
        has = 1'b1;
        if (span < $signed({1'b0, reg_threshold})) begin
          // Arithmetic shift gives the floored midpoint
          total = shzw_pkg::ValueW'(win_hi) + shzw_pkg::ValueW'(win_lo);
          zero_heading = shzw_pkg::YawW'(total >>> 1);
          cal_locked = 1'b1;
          cand_held = 1'b0;
          rep.kind = shzw_pkg::KIND_CAL_DONE;
          rep.value = total >>> 1;
        end else begin
          rep.kind = shzw_pkg::KIND_UNSTABLE;
          rep.value = span;
        end
      end else begin
        win_pos = win_pos + 1'b1;
      end
    end else if (!cand_held) begin
      cand_heading = yaw;
      cand_held = 1'b1;
    end else begin
      cand_held = 1'b0;
      gap = shzw_pkg::ValueW'(yaw) - shzw_pkg::ValueW'(cand_heading);
      if (gap < 0) gap = -gap;
      if (gap <= $signed({1'b0, reg_tolerance})) begin
        // Wrap the relative heading once into half a turn either way
        rel = shzw_pkg::ValueW'(cand_heading) - shzw_pkg::ValueW'(zero_heading);
        if (rel > shzw_pkg::YawLimitV) rel = rel - shzw_pkg::FullTurnV;
        else if (rel < -shzw_pkg::YawLimitV) rel = rel + shzw_pkg::FullTurnV;
        has = 1'b1;
        rep.kind = shzw_pkg::KIND_HEADING;
        rep.value = rel;
      end
    end
  endfunction

  // Mostly no pause, some short, a few long
  function automatic int pick_pause(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [shzw_pkg::YawW-1:0] random_yaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return 16'($urandom);
    if (r < 32) return ($urandom_range(0, 1) != 0) ? shzw_pkg::YawLimit : -shzw_pkg::YawLimit;
    return 16'($urandom_range(0, 36000) - 18000);
  endfunction

  task automatic offer(input int v);
    sample_queue.push_back(16'(v));
    samples_queued++;
  endtask

  // Wait until every item is taken, every report is in, and the pipe is empty
  task automatic settle();
    while (samples_taken != samples_queued) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input shzw_pkg::cfg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      shzw_pkg::CFG_WINDOW_LENGTH:    reg_win_len = val[shzw_pkg::LenW-1:0];
      shzw_pkg::CFG_STABLE_THRESHOLD: reg_threshold = val;
      shzw_pkg::CFG_SETTLE_TOLERANCE: reg_tolerance = val;
      default: ;
    endcase
  endtask

  task automatic shuffle_idling();
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
  endtask

  // Candidate/check pairs around the tolerance edge, with stray single items
  task automatic run_heading_pairs(input int pairs);
    int tol;
    int cand;
    int chk;
    int i;
    tol = int'(reg_tolerance);
    for (i = 0; i < pairs; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        offer(random_yaw());
        continue;
      end
      case ($urandom_range(0, 9))
        0: cand = ($urandom_range(0, 1) != 0) ? 18000 : -18000;
        1: cand = int'(zero_heading) + (($urandom_range(0, 1) != 0) ? 18000 : -18000)
                  + int'($urandom_range(0, 2)) - 1;
        2: cand = $signed(random_yaw());
        default: cand = int'($urandom_range(0, 36000)) - 18000;
      endcase
      case ($urandom_range(0, 9))
        0: chk = cand + tol;
        1: chk = cand - tol;
        2: chk = cand + tol + 1;
        3: chk = cand - tol - 1;
        4: chk = int'($urandom_range(0, 80000)) - 40000;
        default: chk = cand + int'($urandom_range(0, 2 * tol)) - tol;
      endcase
      if (chk > 32767) chk = 32767;
      if (chk < -32768) chk = -32768;
      offer(cand);
      offer(chk);
    end
  endtask

  // Sample driver: hold an item until taken, then pause or send the next
  always @(posedge clk) begin : drive_samples
    report_t rep;
    bit      has;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        samples_taken++;
        predict_report(s_tdata, has, rep);
        if (has) pending_reports.push_back(rep);
      end
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          s_tdata  <= sample_queue.pop_front();
          s_tvalid <= 1'b1;
          send_wait = pick_pause(send_idle);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Report receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin : pace_reports
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (long_hold && !long_hold_done) begin
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_pause(recv_idle);
    end
  end

  // Compare each report with the oldest expected one
  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got kind %0d tdata %h",
                 $time, m_tuser, m_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (m_tuser !== want.kind) begin
          $display("%0t: report kind mismatch, expected %0d, got %0d",
                   $time, want.kind, m_tuser);
          error_count++;
        end
        if (m_tdata !== {{(shzw_pkg::OutDataW - shzw_pkg::ValueW){1'b0}}, want.value}) begin
          $display("%0t: report value mismatch, expected %0d, got %0d (tdata %h)",
                   $time, want.value, $signed(m_tdata[shzw_pkg::ValueW-1:0]), m_tdata);
          error_count++;
        end
      end
    end
  end

  // End the run when no channel moves an item for too long
  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int len;
    int lean;
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: one full default window with a wide spread
    shuffle_idling();
    offer(1000);
    repeat (18) offer(random_yaw());
    offer(-1000);
    settle();

    // One-sample windows over saturated and extreme samples
    write_reg(shzw_pkg::CFG_STABLE_THRESHOLD, 16'd0);
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd1);
    write_reg(shzw_pkg::CFG_UNUSED, 16'hFFFF);
    offer(16'h7FFF);
    offer(16'h8000);
    offer(18000);
    offer(-18000);
    offer(18001);
    offer(-18001);
    offer(0);
    offer(1);
    settle();

    // Zero window length acts as one
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd0);
    offer(-5);
    offer(7);
    settle();

    // Range equal to the threshold is not stable
    write_reg(shzw_pkg::CFG_STABLE_THRESHOLD, 16'd36000);
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd2);
    offer(-18000);
    offer(18000);
    settle();

    // Zero seeds the window, later zeros are skipped
    write_reg(shzw_pkg::CFG_STABLE_THRESHOLD, 16'd0);
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd3);
    offer(0);
    offer(-700);
    offer(0);
    settle();

    // Shrink the window while it is partly filled
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd10);
    offer(300);
    offer(-40);
    offer(0);
    offer(125);
    settle();
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd2);
    offer(-9);
    settle();

    // Random windows that never settle
    for (phase = 0; phase < 12; phase++) begin
      shuffle_idling();
      case ($urandom_range(0, 5))
        0: len = 0;
        1: len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'(len));
      repeat ($urandom_range(10, 30)) offer(random_yaw());
      settle();
    end

    // Long receiver hold-off with a steady sender: the block must back up
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd1);
    long_hold = 1'b1;
    repeat (40) offer(random_yaw());
    settle();
    long_hold = 1'b0;

    // Oversized length saturates to the largest window
    shuffle_idling();
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'hFFFF);
    repeat (1024) offer(random_yaw());
    settle();

    // Close any open window, then calibrate with a known midpoint
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd1);
    offer(random_yaw());
    settle();
    write_reg(shzw_pkg::CFG_STABLE_THRESHOLD, 16'hFFFF);
    write_reg(shzw_pkg::CFG_WINDOW_LENGTH, 16'd4);
    lean = ($urandom_range(0, 1) != 0) ? 1 : -1;
    offer(0);
    offer(1000 * lean);
    offer(0);
    offer(1001 * lean);
    settle();

    // Heading pairs, first under the reset tolerance
    shuffle_idling();
    run_heading_pairs(30);
    settle();
    write_reg(shzw_pkg::CFG_SETTLE_TOLERANCE, 16'd0);
    shuffle_idling();
    run_heading_pairs(30);
    settle();
    write_reg(shzw_pkg::CFG_SETTLE_TOLERANCE, 16'd36000);
    shuffle_idling();
    run_heading_pairs(30);
    settle();
    write_reg(shzw_pkg::CFG_SETTLE_TOLERANCE, 16'hFFFF);
    shuffle_idling();
    run_heading_pairs(25);
    settle();
    for (phase = 0; phase < 2; phase++) begin
      write_reg(shzw_pkg::CFG_SETTLE_TOLERANCE, 16'($urandom_range(1, 3000)));
      shuffle_idling();
      run_heading_pairs(30);
      settle();
    end

    if (error_count == 0 && pending_reports.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
